/* rtl/core/restoring_divider_16_defines.svh */
// assertion macros for the restoring divider rtl
// no dependencies; included inside module bodies that check their own logic
`ifndef RESTORING_DIVIDER_16_DEFINES_SVH
`define RESTORING_DIVIDER_16_DEFINES_SVH
`ifndef SYNTHESIS
`define RDIV_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("restoring divider check failed");
`define RDIV_ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) \
        else $error("restoring divider check failed");
`else
`define RDIV_ASSERT(lbl, clk_s, rst_s, prop)
`define RDIV_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

/* rtl/core/rdiv16_pkg.sv */
// shared types and codes for the restoring divider
// no dependencies
`timescale 1ns / 1ps

package rdiv16_pkg;

    // request kind carried on tuser
    typedef logic [0:0] kind_t;

    localparam kind_t KIND_UNSIGNED = 1'b0;
    localparam kind_t KIND_SIGNED   = 1'b1;

endpackage

/* rtl/core/restoring_divider_16.sv */
// pipelined restoring divider, unsigned or signed, one quotient bit per stage
// depends on rdiv16_pkg and restoring_divider_16_defines.svh
`timescale 1ns / 1ps

// Usage:
//   slave stream s_axis_* takes one division request per accepted beat:
//   tuser selects unsigned (0) or signed two's complement (1), tdata carries
//   dividend and divisor. master stream m_axis_* returns quotient and
//   remainder, one result per request, in request order.
//   Signed results truncate toward zero; the remainder has the dividend's
//   sign. A zero divisor gives an all-ones quotient and the dividend as the
//   remainder in either mode. Most negative over minus one wraps.
//   One stage folds signs into magnitudes, DATA_WIDTH stages each resolve
//   one quotient bit with one subtract and compare, and the output register
//   restores the signs.
//   Throughput is one request per cycle. When the receiver holds tready low
//   while a result is waiting, the whole pipeline holds and s_axis_tready
//   drops; bubbles inside the pipe do not hold it back from the output.
//   Reset clears all valid bits; no request is in flight afterward.
module restoring_divider_16 #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // [DATA_WIDTH-1:0] dividend, [2*DATA_WIDTH-1:DATA_WIDTH] divisor, rest zero
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]             s_axis_tdata,
    // [0] kind
    input  rdiv16_pkg::kind_t                             s_axis_tuser,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // [DATA_WIDTH-1:0] quotient, [2*DATA_WIDTH-1:DATA_WIDTH] remainder, rest zero
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]             m_axis_tdata
);
    import rdiv16_pkg::*;
    `include "restoring_divider_16_defines.svh"

    localparam int TDATA_W = ((2*DATA_WIDTH+7)/8)*8;
    localparam int DW      = DATA_WIDTH;

    // stage 0 is the sign fold, stages 1..DW each produce one quotient bit
    logic [DW:0]   valid_reg;
    logic [DW-1:0] num_reg  [0:DW];
    logic [DW-1:0] div_reg  [0:DW];
    logic [DW-1:0] rem_reg  [0:DW];
    logic [DW-1:0] quo_reg  [0:DW];
    logic [DW:0]   negq_reg;
    logic [DW:0]   negr_reg;

    logic [DW-1:0] num_next [0:DW];
    logic [DW-1:0] rem_next [0:DW];
    logic [DW-1:0] quo_next [0:DW];
    logic [DW:0]   valid_next;
    logic [DW-1:0] div_next [0:DW];
    logic [DW:0]   negq_next;
    logic [DW:0]   negr_next;

    logic          out_valid_reg;
    logic [DW-1:0] out_quo_reg;
    logic [DW-1:0] out_rem_reg;

    logic          advance;
    logic [DW-1:0] in_dividend;
    logic [DW-1:0] in_divisor;
    logic          in_signed;
    logic          in_neg_a;
    logic          in_neg_b;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'({out_rem_reg, out_quo_reg});

    assign in_dividend = s_axis_tdata[DW-1:0];
    assign in_divisor  = s_axis_tdata[2*DW-1:DW];
    // a zero divisor runs as unsigned so the step chain yields all ones and the dividend
    assign in_signed   = (s_axis_tuser == KIND_SIGNED) && (in_divisor != '0);
    assign in_neg_a    = in_signed && in_dividend[DW-1];
    assign in_neg_b    = in_signed && in_divisor[DW-1];

    always_comb
    begin
        logic [DW:0] trial;
        logic [DW:0] diff;
        trial = '0;
        diff  = '0;

        valid_next[0] = s_axis_tvalid;
        num_next[0]   = in_neg_a ? (DW'(0) - in_dividend) : in_dividend;
        div_next[0]   = in_neg_b ? (DW'(0) - in_divisor) : in_divisor;
        rem_next[0]   = '0;
        quo_next[0]   = '0;
        negq_next[0]  = in_neg_a ^ in_neg_b;
        negr_next[0]  = in_neg_a;

        for (int k = 1; k <= DW; k++)
        begin
            trial         = {rem_reg[k-1], num_reg[k-1][DW-1]};
            diff          = trial - {1'b0, div_reg[k-1]};
            valid_next[k] = valid_reg[k-1];
            num_next[k]   = {num_reg[k-1][DW-2:0], 1'b0};
            div_next[k]   = div_reg[k-1];
            // no borrow means the partial remainder covers the divisor
            rem_next[k]   = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
            quo_next[k]   = {quo_reg[k-1][DW-2:0], !diff[DW]};
            negq_next[k]  = negq_reg[k-1];
            negr_next[k]  = negr_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= valid_reg[DW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num_reg     <= num_next;
            div_reg     <= div_next;
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            negq_reg    <= negq_next;
            negr_reg    <= negr_next;
            out_quo_reg <= negq_reg[DW] ? (DW'(0) - quo_reg[DW]) : quo_reg[DW];
            out_rem_reg <= negr_reg[DW] ? (DW'(0) - rem_reg[DW]) : rem_reg[DW];
        end
    end

    // a held pipeline keeps every in-flight request where it is
    `RDIV_ASSERT(a_hold_keeps_valids, clk, rst_n,
        !advance |=> $stable(valid_reg) && $stable(out_valid_reg))

    // an accepted request always lands in the sign-fold stage
    `RDIV_ASSERT(a_accept_enters, clk, rst_n,
        s_axis_tvalid && s_axis_tready |=> valid_reg[0])

    // an emptied output slot is refilled only from the last step stage
    `RDIV_ASSERT(a_out_source, clk, rst_n,
        advance |=> out_valid_reg == $past(valid_reg[DW]))

    // every partial remainder stays below a nonzero divisor
    for (genvar g = 1; g <= DW; g++)
    begin : g_rem_check
        `RDIV_ASSERT(a_rem_below_div, clk, rst_n,
            valid_reg[g] |-> (div_reg[g] == '0) || (rem_reg[g] < div_reg[g]))
    end

endmodule

/* sim/tb_top.sv */
// self-checking bench for restoring_divider_16: directed corner requests, then mixed random ones
// depends on rdiv16_pkg and the restoring_divider_16 rtl
`timescale 1ns / 1ps

module tb_top;

    import rdiv16_pkg::*;

    localparam int DATA_WIDTH = 16;
    localparam int BUS_WIDTH  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_REQUESTS = 2000;

    typedef logic [DATA_WIDTH-1:0] word_t;

    // remainder in the upper half, quotient in the lower half, as on m_axis_tdata
    typedef struct packed {
        word_t remainder;
        word_t quotient;
    } quo_rem_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [15:0] dividend, [31:16] divisor
    logic [BUS_WIDTH-1:0] s_axis_tdata  = '0;
    // [0] kind
    kind_t                s_axis_tuser  = KIND_UNSIGNED;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [15:0] quotient, [31:16] remainder
    logic [BUS_WIDTH-1:0] m_axis_tdata;

    quo_rem_t quo_rem_queue[$];
    int       mismatch_count = 0;
    logic     steady         = 1'b0;

    restoring_divider_16 #(
        .DATA_WIDTH(DATA_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // bitwise restoring division on magnitudes, signs applied afterward
    function automatic quo_rem_t predict_division(kind_t kind, word_t a, word_t b);
        quo_rem_t            res;
        logic                neg_a;
        logic                neg_b;
        word_t               mag_a;
        word_t               mag_b;
        word_t               quo;
        word_t               rem;
        logic [DATA_WIDTH:0] part;
        int                  i;
        if (b == '0)
        begin
            res.quotient  = '1;
            res.remainder = a;
            return res;
        end
        neg_a = (kind == KIND_SIGNED) && a[DATA_WIDTH-1];
        neg_b = (kind == KIND_SIGNED) && b[DATA_WIDTH-1];
        // negating the most negative value leaves it as its own unsigned magnitude
        mag_a = neg_a ? word_t'(-a) : a;
        mag_b = neg_b ? word_t'(-b) : b;
        part  = '0;
        quo   = '0;
        for (i = DATA_WIDTH - 1; i >= 0; i--)
        begin
            part = {part[DATA_WIDTH-1:0], mag_a[i]};
            if (part >= {1'b0, mag_b})
            begin
                part   = part - {1'b0, mag_b};
                quo[i] = 1'b1;
            end
        end
        rem           = part[DATA_WIDTH-1:0];
        res.quotient  = (neg_a != neg_b) ? word_t'(-quo) : quo;
        res.remainder = neg_a ? word_t'(-rem) : rem;
        return res;
    endfunction

    // called right after a rising edge; returns right after the edge that took the request
    task automatic send_division(input kind_t kind, input word_t a, input word_t b);
        while (!steady && $urandom_range(99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        quo_rem_queue.push_back(predict_division(kind, a, b));
    endtask

    // random operand with extra weight on corner values and small magnitudes
    function automatic word_t pick_operand();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0:       return '0;
                    1:       return word_t'(1);
                    2:       return '1;
                    3:       return word_t'(16'h8000);
                    default: return word_t'(16'h7fff);
                endcase
            end
            1:       return word_t'($urandom_range(15));
            2:       return word_t'(-$urandom_range(15));
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic test_zero_divisor();
        send_division(KIND_UNSIGNED, 16'h0000, 16'h0000);
        send_division(KIND_UNSIGNED, 16'hffff, 16'h0000);
        send_division(KIND_SIGNED,   16'h8000, 16'h0000);
        send_division(KIND_SIGNED,   16'h1234, 16'h0000);
    endtask

    task automatic test_signed_overflow();
        send_division(KIND_SIGNED,   16'h8000, 16'hffff);
        send_division(KIND_UNSIGNED, 16'h8000, 16'hffff);
    endtask

    task automatic test_zero_dividend();
        send_division(KIND_UNSIGNED, 16'h0000, 16'h0007);
        send_division(KIND_SIGNED,   16'h0000, 16'hffff);
        send_division(KIND_SIGNED,   16'h0000, 16'h8000);
        send_division(KIND_SIGNED,   16'h0000, 16'h0001);
    endtask

    task automatic test_operand_extremes();
        send_division(KIND_UNSIGNED, 16'hffff, 16'h0001);
        send_division(KIND_UNSIGNED, 16'hffff, 16'hffff);
        send_division(KIND_UNSIGNED, 16'h0001, 16'hffff);
        send_division(KIND_UNSIGNED, 16'h8000, 16'h8000);
        send_division(KIND_SIGNED,   16'h7fff, 16'h8000);
        send_division(KIND_SIGNED,   16'h8000, 16'h8000);
        send_division(KIND_SIGNED,   16'h8000, 16'h0001);
        send_division(KIND_SIGNED,   16'h7fff, 16'hffff);
        send_division(KIND_SIGNED,   16'hfff9, 16'h0002);
        send_division(KIND_SIGNED,   16'h0007, 16'hfffe);
        send_division(KIND_SIGNED,   16'hfff9, 16'hfffe);
    endtask

    task automatic test_random_mixed();
        int n;
        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // both sides run without gaps through this window
            steady <= (n >= 800 && n < 1200);
            send_division(kind_t'($urandom_range(1)), pick_operand(), pick_operand());
        end
        steady <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(99) >= 9);
    end

    always @(posedge clk)
    begin
        quo_rem_t want;
        quo_rem_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (quo_rem_queue.size() == 0)
            begin
                $error("result with no request pending: quotient %h remainder %h",
                       got.quotient, got.remainder);
                mismatch_count++;
            end
            else
            begin
                want = quo_rem_queue.pop_front();
                if (got.quotient !== want.quotient)
                begin
                    $error("quotient: expected %h, actual %h", want.quotient, got.quotient);
                    mismatch_count++;
                end
                if (got.remainder !== want.remainder)
                begin
                    $error("remainder: expected %h, actual %h", want.remainder, got.remainder);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_divisor();
        test_signed_overflow();
        test_zero_dividend();
        test_operand_extremes();
        test_random_mixed();
        s_axis_tvalid <= 1'b0;
        while (quo_rem_queue.size() != 0)
            @(posedge clk);
        repeat (DATA_WIDTH + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/rdiv16_pkg.sv
rtl/core/restoring_divider_16.sv
sim/tb_top.sv
